/* rtl/npc_pkg.sv */
package npc_pkg;

   localparam int CHAN_W           = 8;
   localparam int INDEX_W          = 8;
   localparam int PROD_W           = 2 * CHAN_W;
   localparam int DIST_W           = 18;
   localparam int PALETTE_SIZE_DEF = 256;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_PIXEL = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_en;
      logic pixel_cap;
      logic mul_en;
      logic div_en;
      logic rd_en;
      logic rd_first;
      logic rd_last;
      logic res_load;
   } npc_cmd_type;

   // status from the datapath back to the controller
   typedef struct packed {
      logic scan_done;
      logic rsp_busy;
   } npc_status_type;

   // floor(x / 255) for any product of two channels
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] s;
      s = {1'b0, x} + {{(CHAN_W + 1){1'b0}}, x[PROD_W-1:CHAN_W]} + {{PROD_W{1'b0}}, 1'b1};
      return s[PROD_W-1:CHAN_W];
   endfunction

endpackage

/* rtl/npc_datapath.sv */
module npc_datapath #(
   parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF,
   parameter int ADDR_W       = $clog2(PALETTE_SIZE)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  npc_pkg::npc_cmd_type        cmd,
   output npc_pkg::npc_status_type     status,
   input  logic [ADDR_W-1:0]           rd_addr,
   input  logic [npc_pkg::INDEX_W-1:0] entry_index,
   input  logic [npc_pkg::CHAN_W-1:0]  entry_red,
   input  logic [npc_pkg::CHAN_W-1:0]  entry_green,
   input  logic [npc_pkg::CHAN_W-1:0]  entry_blue,
   input  logic [npc_pkg::CHAN_W-1:0]  pixel_red,
   input  logic [npc_pkg::CHAN_W-1:0]  pixel_green,
   input  logic [npc_pkg::CHAN_W-1:0]  pixel_blue,
   input  logic [npc_pkg::CHAN_W-1:0]  pixel_alpha,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [npc_pkg::INDEX_W-1:0] color_index
);
   import npc_pkg::*;

   logic [3*CHAN_W-1:0] palette_mem [PALETTE_SIZE];

   logic [CHAN_W-1:0] pr_ff, pg_ff, pb_ff, pa_ff;
   logic [PROD_W-1:0] prod_r_ff, prod_g_ff, prod_b_ff;
   logic [CHAN_W-1:0] qr_ff, qg_ff, qb_ff;

   logic [3*CHAN_W-1:0] entry_ff;
   logic                v1_ff, first1_ff, last1_ff;
   logic [ADDR_W-1:0]   idx1_ff;

   logic [PROD_W-1:0] sq_r_ff, sq_g_ff, sq_b_ff;
   logic              v2_ff, first2_ff, last2_ff;
   logic [ADDR_W-1:0] idx2_ff;

   logic [DIST_W-1:0] best_dist_ff;
   logic [ADDR_W-1:0] best_idx_ff;
   logic              done_ff;

   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  rsp_data_ff;

   logic [CHAN_W-1:0] diff_r, diff_g, diff_b;
   logic [DIST_W-1:0] dist_sum;

   // palette store, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         palette_mem[entry_index[ADDR_W-1:0]] <= {entry_red, entry_green, entry_blue};
      end
      if (cmd.rd_en) begin
         entry_ff <= palette_mem[rd_addr];
      end
   end

   // premultiply by alpha: product then divide by 255
   always_ff @(posedge clock) begin
      if (cmd.pixel_cap) begin
         pr_ff <= pixel_red;
         pg_ff <= pixel_green;
         pb_ff <= pixel_blue;
         pa_ff <= pixel_alpha;
      end
      if (cmd.mul_en) begin
         prod_r_ff <= PROD_W'(pa_ff) * PROD_W'(pr_ff);
         prod_g_ff <= PROD_W'(pa_ff) * PROD_W'(pg_ff);
         prod_b_ff <= PROD_W'(pa_ff) * PROD_W'(pb_ff);
      end
      if (cmd.div_en) begin
         qr_ff <= div255(prod_r_ff);
         qg_ff <= div255(prod_g_ff);
         qb_ff <= div255(prod_b_ff);
      end
   end

   always_comb begin
      diff_r = (qr_ff > entry_ff[3*CHAN_W-1:2*CHAN_W]) ?
               qr_ff - entry_ff[3*CHAN_W-1:2*CHAN_W] : entry_ff[3*CHAN_W-1:2*CHAN_W] - qr_ff;
      diff_g = (qg_ff > entry_ff[2*CHAN_W-1:CHAN_W]) ?
               qg_ff - entry_ff[2*CHAN_W-1:CHAN_W] : entry_ff[2*CHAN_W-1:CHAN_W] - qg_ff;
      diff_b = (qb_ff > entry_ff[CHAN_W-1:0]) ?
               qb_ff - entry_ff[CHAN_W-1:0] : entry_ff[CHAN_W-1:0] - qb_ff;
      dist_sum = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
   end

   // scan pipeline: read, square, sum and compare
   always_ff @(posedge clock) begin
      idx1_ff   <= rd_addr;
      first1_ff <= cmd.rd_first;
      last1_ff  <= cmd.rd_last;
      if (v1_ff) begin
         sq_r_ff <= PROD_W'(diff_r) * PROD_W'(diff_r);
         sq_g_ff <= PROD_W'(diff_g) * PROD_W'(diff_g);
         sq_b_ff <= PROD_W'(diff_b) * PROD_W'(diff_b);
      end
      idx2_ff   <= idx1_ff;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      // strict less-than keeps the lowest index on a tie
      if (v2_ff && (first2_ff || (dist_sum < best_dist_ff))) begin
         best_dist_ff <= dist_sum;
         best_idx_ff  <= idx2_ff;
      end
      if (cmd.res_load) begin
         rsp_data_ff <= INDEX_W'(best_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff   <= cmd.rd_en;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff & last2_ff;
         if (cmd.res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.scan_done = done_ff;
   assign status.rsp_busy  = rsp_valid_ff;
   assign rsp_tvalid       = rsp_valid_ff;
   assign color_index      = rsp_data_ff;

endmodule

/* rtl/npc_control.sv */
module npc_control #(
   parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF,
   parameter int ADDR_W       = $clog2(PALETTE_SIZE)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        action,
   input  logic [npc_pkg::INDEX_W-1:0] entry_index,
   input  logic                        rsp_tready,
   input  npc_pkg::npc_status_type     status,
   output npc_pkg::npc_cmd_type        cmd,
   output logic [ADDR_W-1:0]           rd_addr
);
   import npc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_SIZE - 1);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              accept;
   logic              slot_ok;

   assign accept  = req_tvalid && (state_ff == ST_IDLE);
   assign slot_ok = {1'b0, entry_index} < (INDEX_W + 1)'(PALETTE_SIZE);

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (action == ACTION_LOAD) begin
                  cmd.load_en = slot_ok;
               end else begin
                  cmd.pixel_cap = 1'b1;
                  state_in      = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            addr_in    = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_first = (addr_ff == '0);
            cmd.rd_last  = (addr_ff == LAST_ADDR);
            addr_in      = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.rsp_busy || rsp_tready) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rd_addr    = addr_ff;

endmodule

/* rtl/nearest_palette_color_top.sv */
// load item: entry written on accept if its index is in range, no result, next item taken the cycle after
// pixel item: captured, premultiplied by alpha, then compared against every palette entry
// the next item is taken only once the best index has gone to the output register; the
// scan reads one entry a cycle, and a result still waiting there holds the next one back
// synchronous active-high reset clears control state only; palette contents
// are undefined until loaded
module nearest_palette_color_top #(
   parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // entry_index, entry_red, entry_green, entry_blue,
                                   // pixel_red, pixel_green, pixel_blue, pixel_alpha
   input  logic [0:0]  req_tuser,  // action
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // color_index
);
   import npc_pkg::*;

   localparam int ADDR_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

   npc_cmd_type       cmd;
   npc_status_type    status;
   logic [ADDR_W-1:0] rd_addr;

   // unpack the item, lowest field first
   logic [INDEX_W-1:0] entry_index;
   logic [CHAN_W-1:0]  entry_red, entry_green, entry_blue;
   logic [CHAN_W-1:0]  pixel_red, pixel_green, pixel_blue, pixel_alpha;

   assign entry_index = req_tdata[7:0];
   assign entry_red   = req_tdata[15:8];
   assign entry_green = req_tdata[23:16];
   assign entry_blue  = req_tdata[31:24];
   assign pixel_red   = req_tdata[39:32];
   assign pixel_green = req_tdata[47:40];
   assign pixel_blue  = req_tdata[55:48];
   assign pixel_alpha = req_tdata[63:56];

   // sequencer: load writes, premultiply steps, palette scan, result hand-off
   npc_control #(
      .PALETTE_SIZE (PALETTE_SIZE),
      .ADDR_W       (ADDR_W)
   ) u_control (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .action      (req_tuser[0]),
      .entry_index (entry_index),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd),
      .rd_addr     (rd_addr)
   );

   // palette store, premultiply, distance pipeline and output register
   npc_datapath #(
      .PALETTE_SIZE (PALETTE_SIZE),
      .ADDR_W       (ADDR_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .rd_addr     (rd_addr),
      .entry_index (entry_index),
      .entry_red   (entry_red),
      .entry_green (entry_green),
      .entry_blue  (entry_blue),
      .pixel_red   (pixel_red),
      .pixel_green (pixel_green),
      .pixel_blue  (pixel_blue),
      .pixel_alpha (pixel_alpha),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .color_index (rsp_tdata)
   );

endmodule
